FILE: src/cursor_sequence_list_engine_macros.svh
`ifndef CURSOR_SEQUENCE_LIST_ENGINE_MACROS_SVH
`define CURSOR_SEQUENCE_LIST_ENGINE_MACROS_SVH

// same-cycle implication, checked on clk, off during reset
`define CSLE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk, off during reset
`define CSLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/csle_pkg.sv
package csle_pkg;

  localparam int MODE_W = 3;
  localparam int OUT_USER_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_START  = 3'd0,
    MODE_ADV    = 3'd1,
    MODE_INSERT = 3'd2,
    MODE_ATTACH = 3'd3,
    MODE_REMOVE = 3'd4,
    MODE_CLEAR  = 3'd5,
    MODE_QUERY  = 3'd6
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RD   = 3'b010,
    S_FIN  = 3'b100
  } st_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

FILE: src/csle_ram.sv
module csle_ram
  import csle_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  mem_ctl_t         ctl,
  input  logic [AW-1:0]    rd_addr,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // read-first: a same-cycle write to the read address returns old data
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/csle_ctrl.sv
module csle_ctrl
  import csle_pkg::*;
#(
  parameter int CAPACITY = 256,
  parameter int DATA_WIDTH = 32,
  localparam int AW = $clog2(CAPACITY),
  localparam int PW = $clog2(CAPACITY + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [MODE_W-1:0]     in_mode,
  input  logic [DATA_WIDTH-1:0] in_value,
  input  logic                  out_free,
  output logic                  res_valid,
  output logic [DATA_WIDTH-1:0] res_value,
  output logic                  res_has,
  output logic [PW-1:0]         res_count,
  output logic                  res_error,
  output mem_ctl_t              link_ctl,
  output mem_ctl_t              data_ctl,
  output logic [AW-1:0]         rd_addr,
  output logic [AW-1:0]         link_wr_addr,
  output logic [PW-1:0]         link_wr_data,
  output logic [AW-1:0]         data_wr_addr,
  output logic [DATA_WIDTH-1:0] data_wr_data,
  input  logic [PW-1:0]         link_rd_data,
  input  logic [DATA_WIDTH-1:0] data_rd_data
);

  localparam logic [PW-1:0] NULL_IDX = PW'(CAPACITY);

  st_t                   st_r, st_nxt;
  logic [MODE_W-1:0]     mode_r;
  logic [DATA_WIDTH-1:0] value_r;
  logic [PW-1:0]         head_r, head_nxt;
  logic [PW-1:0]         tail_r, tail_nxt;
  logic [PW-1:0]         cur_r, cur_nxt;
  logic [PW-1:0]         prev_r, prev_nxt;
  logic [PW-1:0]         cnt_r, cnt_nxt;
  logic [PW-1:0]         fhead_r, fhead_nxt;
  logic [PW-1:0]         fresh_r, fresh_nxt;
  logic [DATA_WIDTH-1:0] cdata_r, cdata_nxt;
  logic [PW-1:0]         clink_r, clink_nxt;

  logic          have, full, head_case, tail_case, use_free, finish, accept, err;
  logic [PW-1:0] new_idx, rd_ptr, lw_ptr;

  assign have      = cur_r != NULL_IDX;
  assign full      = cnt_r == NULL_IDX;
  assign head_case = !have || cur_r == head_r;
  assign tail_case = !have || cur_r == tail_r;
  assign use_free  = fhead_r != NULL_IDX;
  assign new_idx   = use_free ? fhead_r : fresh_r;

  assign finish   = st_r == S_FIN && out_free;
  assign in_ready = st_r == S_IDLE || finish;
  assign accept   = in_valid && in_ready;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (accept) st_nxt = S_RD;
      S_RD:   st_nxt = S_FIN;
      S_FIN: begin
        if (accept) begin
          st_nxt = S_RD;
        end else if (finish) begin
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // read: node that becomes current, or the free-list top being popped
  always_comb begin
    unique case (mode_r) inside
      MODE_START:                rd_ptr = head_r;
      MODE_ADV, MODE_REMOVE:     rd_ptr = clink_r;
      MODE_INSERT, MODE_ATTACH:  rd_ptr = fhead_r;
      default:                   rd_ptr = NULL_IDX;
    endcase
  end

  assign data_ctl = '{rd_en: link_ctl.rd_en,
                      wr_en: st_r == S_RD && !full &&
                             (mode_r == MODE_INSERT || mode_r == MODE_ATTACH)};
  assign rd_addr  = rd_ptr[AW-1:0];

  // link writes: neighbor link in the read cycle, own link in the finish cycle
  always_comb begin
    link_ctl.rd_en = st_r == S_RD && rd_ptr != NULL_IDX;
    link_ctl.wr_en = 1'b0;
    lw_ptr         = NULL_IDX;
    link_wr_data   = NULL_IDX;
    if (st_r == S_RD) begin
      unique case (mode_r)
        MODE_INSERT: begin
          link_ctl.wr_en = !full && !head_case;
          lw_ptr         = prev_r;
          link_wr_data   = new_idx;
        end
        MODE_ATTACH: begin
          link_ctl.wr_en = !full && (!tail_case || cnt_r != '0);
          lw_ptr         = tail_case ? tail_r : cur_r;
          link_wr_data   = new_idx;
        end
        MODE_REMOVE: begin
          link_ctl.wr_en = have && cur_r != head_r;
          lw_ptr         = prev_r;
          link_wr_data   = clink_r;
        end
        default: ;
      endcase
    end else if (finish) begin
      unique case (mode_r)
        MODE_INSERT: begin
          link_ctl.wr_en = !full;
          lw_ptr         = new_idx;
          link_wr_data   = head_case ? head_r : cur_r;
        end
        MODE_ATTACH: begin
          link_ctl.wr_en = !full;
          lw_ptr         = new_idx;
          link_wr_data   = tail_case ? NULL_IDX : clink_r;
        end
        MODE_REMOVE: begin
          link_ctl.wr_en = have;
          lw_ptr         = cur_r;
          link_wr_data   = fhead_r;
        end
        default: ;
      endcase
    end
  end

  assign link_wr_addr   = lw_ptr[AW-1:0];
  assign data_wr_addr   = new_idx[AW-1:0];
  assign data_wr_data   = value_r;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    cur_nxt   = cur_r;
    prev_nxt  = prev_r;
    cnt_nxt   = cnt_r;
    fhead_nxt = fhead_r;
    fresh_nxt = fresh_r;
    cdata_nxt = cdata_r;
    clink_nxt = clink_r;
    err       = 1'b0;
    unique case (mode_r) inside
      MODE_START: begin
        cur_nxt   = head_r;
        prev_nxt  = NULL_IDX;
        cdata_nxt = data_rd_data;
        clink_nxt = link_rd_data;
      end
      MODE_ADV: begin
        if (!have) begin
          err = 1'b1;
        end else if (clink_r == NULL_IDX) begin
          cur_nxt  = NULL_IDX;
          prev_nxt = NULL_IDX;
        end else begin
          prev_nxt  = cur_r;
          cur_nxt   = clink_r;
          cdata_nxt = data_rd_data;
          clink_nxt = link_rd_data;
        end
      end
      MODE_INSERT, MODE_ATTACH: begin
        if (full) begin
          err = 1'b1;
        end else begin
          if (use_free) begin
            fhead_nxt = link_rd_data;
          end else begin
            fresh_nxt = fresh_r + 1'b1;
          end
          cnt_nxt   = cnt_r + 1'b1;
          cur_nxt   = new_idx;
          cdata_nxt = value_r;
          if (mode_r == MODE_INSERT) begin
            if (head_case) begin
              head_nxt  = new_idx;
              prev_nxt  = NULL_IDX;
              clink_nxt = head_r;
              if (cnt_r == '0) begin
                tail_nxt = new_idx;
              end
            end else begin
              clink_nxt = cur_r;
            end
          end else begin
            if (tail_case) begin
              if (cnt_r == '0) begin
                head_nxt = new_idx;
              end
              prev_nxt  = tail_r;
              tail_nxt  = new_idx;
              clink_nxt = NULL_IDX;
            end else begin
              prev_nxt  = cur_r;
              clink_nxt = clink_r;
            end
          end
        end
      end
      MODE_REMOVE: begin
        if (!have) begin
          err = 1'b1;
        end else begin
          cnt_nxt   = cnt_r - 1'b1;
          fhead_nxt = cur_r;
          if (cur_r == tail_r) begin
            tail_nxt = prev_r;
          end
          if (cur_r == head_r) begin
            head_nxt = clink_r;
          end
          if (clink_r == NULL_IDX) begin
            cur_nxt  = NULL_IDX;
            prev_nxt = NULL_IDX;
          end else begin
            cur_nxt   = clink_r;
            cdata_nxt = data_rd_data;
            clink_nxt = link_rd_data;
          end
        end
      end
      MODE_CLEAR: begin
        head_nxt  = NULL_IDX;
        tail_nxt  = NULL_IDX;
        cur_nxt   = NULL_IDX;
        prev_nxt  = NULL_IDX;
        cnt_nxt   = '0;
        fhead_nxt = NULL_IDX;
        fresh_nxt = '0;
      end
      default: ;
    endcase
  end

  assign res_valid = finish;
  assign res_has   = cur_nxt != NULL_IDX;
  assign res_value = res_has ? cdata_nxt : '0;
  assign res_count = cnt_nxt;
  assign res_error = err;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      head_r  <= NULL_IDX;
      tail_r  <= NULL_IDX;
      cur_r   <= NULL_IDX;
      prev_r  <= NULL_IDX;
      cnt_r   <= '0;
      fhead_r <= NULL_IDX;
      fresh_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (finish) begin
        head_r  <= head_nxt;
        tail_r  <= tail_nxt;
        cur_r   <= cur_nxt;
        prev_r  <= prev_nxt;
        cnt_r   <= cnt_nxt;
        fhead_r <= fhead_nxt;
        fresh_r <= fresh_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r  <= in_mode;
      value_r <= in_value;
    end
    if (finish) begin
      cdata_r <= cdata_nxt;
      clink_r <= clink_nxt;
    end
  end

endmodule

FILE: src/cursor_sequence_list_engine.sv
// Ordered list of up to CAPACITY values in a node pool, with a cursor on the
// current entry. Each command item returns one result item: the value at the
// cursor, whether there is one, the entry count and an error flag. A command
// has a read state and a finish state. The read state reads the node and link
// memories at the entry that becomes current (or the top of the free list)
// and writes the new value and the neighbor link; the finish state writes the
// node's own link and forms the result; the next command is accepted there.
// The finish state waits while the result register still holds an untaken
// result. Clear is a single command; there is no clearing pass after reset.
module cursor_sequence_list_engine
  import csle_pkg::*;
#(
  parameter int CAPACITY = 256,
  parameter int DATA_WIDTH = 32,
  localparam int CNT_W = $clog2(CAPACITY + 1),
  localparam int AW = $clog2(CAPACITY),
  localparam int IN_TDATA_W = ((DATA_WIDTH + 7) / 8) * 8,
  localparam int OUT_TDATA_W = ((DATA_WIDTH + CNT_W + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // value
  input  logic [MODE_W-1:0]      in_tuser,   // mode
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // current_value, item_count
  output logic [OUT_USER_W-1:0]  out_tuser   // has_item, error
);

  mem_ctl_t              link_ctl, data_ctl;
  logic [AW-1:0]         rd_addr, link_wr_addr, data_wr_addr;
  logic [CNT_W-1:0]      link_wr_data, link_rd_data;
  logic [DATA_WIDTH-1:0] data_wr_data, data_rd_data;
  logic                  out_free, res_valid, res_has, res_error;
  logic [DATA_WIDTH-1:0] res_value;
  logic [CNT_W-1:0]      res_count;

  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [OUT_USER_W-1:0]  out_user_r;

  assign out_free = !out_valid_r || out_tready;

  csle_ctrl #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_mode      (in_tuser),
    .in_value     (in_tdata[DATA_WIDTH-1:0]),
    .out_free     (out_free),
    .res_valid    (res_valid),
    .res_value    (res_value),
    .res_has      (res_has),
    .res_count    (res_count),
    .res_error    (res_error),
    .link_ctl     (link_ctl),
    .data_ctl     (data_ctl),
    .rd_addr      (rd_addr),
    .link_wr_addr (link_wr_addr),
    .link_wr_data (link_wr_data),
    .data_wr_addr (data_wr_addr),
    .data_wr_data (data_wr_data),
    .link_rd_data (link_rd_data),
    .data_rd_data (data_rd_data)
  );

  csle_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (CNT_W)
  ) u_link_ram (
    .clk     (clk),
    .ctl     (link_ctl),
    .rd_addr (rd_addr),
    .wr_addr (link_wr_addr),
    .wr_data (link_wr_data),
    .rd_data (link_rd_data)
  );

  csle_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_WIDTH)
  ) u_data_ram (
    .clk     (clk),
    .ctl     (data_ctl),
    .rd_addr (rd_addr),
    .wr_addr (data_wr_addr),
    .wr_data (data_wr_data),
    .rd_data (data_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data_r <= OUT_TDATA_W'({res_count, res_value});
      out_user_r <= {res_error, res_has};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

FILE: src/csle_chk.sv
`include "cursor_sequence_list_engine_macros.svh"

module csle_chk
  import csle_pkg::*;
#(
  parameter int CAPACITY = 256,
  parameter int DATA_WIDTH = 32,
  localparam int CNT_W = $clog2(CAPACITY + 1),
  localparam int OUT_TDATA_W = ((DATA_WIDTH + CNT_W + 7) / 8) * 8
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [OUT_USER_W-1:0]  out_tuser
);

  `CSLE_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")
  `CSLE_ASSERT_NEXT(a_one_in_flight, in_tvalid && in_tready,
    !in_tready, "command taken in the cycle after an accept")
  `CSLE_ASSERT_NOW(a_empty_value, out_tvalid && !out_tuser[0],
    out_tdata[DATA_WIDTH-1:0] == '0, "nonzero value without a current entry")
  `CSLE_ASSERT_NOW(a_count_range, out_tvalid,
    out_tdata[DATA_WIDTH +: CNT_W] <= CNT_W'(CAPACITY), "count above capacity")
  `CSLE_ASSERT_NOW(a_entry_needs_count, out_tvalid && out_tuser[0],
    out_tdata[DATA_WIDTH +: CNT_W] != '0, "current entry in an empty list")

endmodule

bind cursor_sequence_list_engine csle_chk #(
  .CAPACITY   (CAPACITY),
  .DATA_WIDTH (DATA_WIDTH)
) u_csle_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

FILE: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import csle_pkg::*;

  localparam int POOL = 256;
  localparam logic [8:0] NIL = 9'd256;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 4000;
  localparam int N_DIR = 25;

  typedef struct packed {
    logic [31:0] cur;
    logic        has;
    logic [8:0]  cnt;
    logic        err;
  } cursor_view_t;

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [31:0]       value;
    bit                typed;
    cursor_view_t      want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [31:0] in_tdata = '0;
  logic [MODE_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int sent = 0;
  int mismatches = 0;
  int hold_asks = 0;
  int hold_served = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  cursor_view_t awaited_views [$];
  cursor_view_t got_view;
  cursor_view_t want_view;

  // list shadow
  logic [31:0] pool_data [POOL];
  logic [8:0]  pool_link [POOL];
  logic [8:0]  spare_stack [POOL];
  logic [8:0]  spare_top, fresh_ptr, head_ix, tail_ix, cur_ix, prev_ix, entries;

  dir_row_t plan [N_DIR] = '{
    '{MODE_QUERY,  32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 9'd0, 1'b0}},
    '{MODE_ADV,    32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 9'd0, 1'b1}},
    '{MODE_REMOVE, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 9'd0, 1'b1}},
    '{MODE_START,  32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 9'd0, 1'b0}},
    '{MODE_INSERT, 32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 1'b1, 9'd1, 1'b0}},
    '{MODE_ATTACH, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b1, 9'd2, 1'b0}},
    '{MODE_UNUSED, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 1'b1, 9'd2, 1'b0}},
    '{MODE_START,  32'h0000_0000, 1'b0, '0},
    '{MODE_ADV,    32'h0000_0000, 1'b0, '0},
    '{MODE_INSERT, 32'hA5A5_A5A5, 1'b0, '0},
    '{MODE_ATTACH, 32'h5A5A_5A5A, 1'b0, '0},
    '{MODE_ADV,    32'h0000_0000, 1'b0, '0},
    '{MODE_ADV,    32'h0000_0000, 1'b0, '0},
    '{MODE_ADV,    32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 9'd4, 1'b1}},
    '{MODE_START,  32'h0000_0000, 1'b0, '0},
    '{MODE_ADV,    32'h0000_0000, 1'b0, '0},
    '{MODE_ADV,    32'h0000_0000, 1'b0, '0},
    '{MODE_ADV,    32'h0000_0000, 1'b0, '0},
    '{MODE_REMOVE, 32'h0000_0000, 1'b0, '0},
    '{MODE_START,  32'h0000_0000, 1'b0, '0},
    '{MODE_REMOVE, 32'h0000_0000, 1'b0, '0},
    '{MODE_CLEAR,  32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 1'b0, 9'd0, 1'b0}},
    '{MODE_ATTACH, 32'h1234_5678, 1'b1, '{32'h1234_5678, 1'b1, 9'd1, 1'b0}},
    '{MODE_REMOVE, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 9'd0, 1'b0}},
    '{MODE_INSERT, 32'h0000_0001, 1'b0, '0}
  };

  cursor_sequence_list_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit real_ix(logic [8:0] ix);
    return !ix[8];
  endfunction

  function automatic logic [8:0] next_of(logic [8:0] ix);
    return real_ix(ix) ? pool_link[ix[7:0]] : NIL;
  endfunction

  function automatic void empty_list();
    spare_top = '0;
    fresh_ptr = '0;
    head_ix = NIL;
    tail_ix = NIL;
    cur_ix = NIL;
    prev_ix = NIL;
    entries = '0;
  endfunction

  function automatic logic [8:0] grab_node();
    logic [8:0] n;
    if (spare_top > 0) begin
      spare_top = spare_top - 9'd1;
      n = spare_stack[spare_top[7:0]];
    end else begin
      n = fresh_ptr;
      fresh_ptr = fresh_ptr + 9'd1;
    end
    return real_ix(n) ? n : 9'd0;
  endfunction

  function automatic cursor_view_t predict_list_cmd(logic [MODE_W-1:0] m, logic [31:0] v);
    cursor_view_t r;
    logic bad;
    logic had;
    logic [8:0] n;
    logic [8:0] nx;
    bad = 1'b0;
    had = real_ix(cur_ix);
    case (m)
      MODE_START: begin
        cur_ix = head_ix;
        prev_ix = NIL;
      end
      MODE_ADV: begin
        if (!had) begin
          bad = 1'b1;
        end else if (cur_ix == tail_ix) begin
          cur_ix = NIL;
          prev_ix = NIL;
        end else begin
          prev_ix = cur_ix;
          cur_ix = next_of(cur_ix);
        end
      end
      MODE_INSERT: begin
        if (entries >= POOL) begin
          bad = 1'b1;
        end else begin
          n = grab_node();
          pool_data[n[7:0]] = v;
          entries = entries + 9'd1;
          if (!had || cur_ix == head_ix) begin
            pool_link[n[7:0]] = head_ix;
            head_ix = n;
            prev_ix = NIL;
            if (entries == 1) tail_ix = n;
          end else begin
            pool_link[n[7:0]] = cur_ix;
            if (real_ix(prev_ix)) pool_link[prev_ix[7:0]] = n;
          end
          cur_ix = n;
        end
      end
      MODE_ATTACH: begin
        if (entries >= POOL) begin
          bad = 1'b1;
        end else begin
          n = grab_node();
          pool_data[n[7:0]] = v;
          entries = entries + 9'd1;
          if (!had || cur_ix == tail_ix) begin
            if (entries == 1) head_ix = n;
            else if (real_ix(tail_ix)) pool_link[tail_ix[7:0]] = n;
            prev_ix = tail_ix;
            tail_ix = n;
            pool_link[n[7:0]] = NIL;
          end else begin
            pool_link[n[7:0]] = next_of(cur_ix);
            pool_link[cur_ix[7:0]] = n;
            prev_ix = cur_ix;
          end
          cur_ix = n;
        end
      end
      MODE_REMOVE: begin
        if (!had) begin
          bad = 1'b1;
        end else begin
          if (entries > 0) entries = entries - 9'd1;
          n = cur_ix;
          nx = next_of(n);
          if (n == tail_ix) tail_ix = prev_ix;
          if (n == head_ix) head_ix = nx;
          else if (real_ix(prev_ix)) pool_link[prev_ix[7:0]] = nx;
          cur_ix = nx;
          // tail removed: predecessor goes with the cursor
          if (!real_ix(cur_ix)) begin
            cur_ix = NIL;
            prev_ix = NIL;
          end
          if (real_ix(n) && spare_top < POOL) begin
            spare_stack[spare_top[7:0]] = n;
            spare_top = spare_top + 9'd1;
          end
        end
      end
      MODE_CLEAR: empty_list();
      default: ;
    endcase
    r.has = real_ix(cur_ix);
    r.cur = r.has ? pool_data[cur_ix[7:0]] : 32'h0;
    r.cnt = entries;
    r.err = bad;
    return r;
  endfunction

  function automatic logic [MODE_W-1:0] edit_mode();
    int p;
    p = $urandom_range(99);
    if (p < 27) return MODE_ATTACH;
    if (p < 52) return MODE_INSERT;
    if (p < 70) return MODE_ADV;
    if (p < 85) return MODE_REMOVE;
    if (p < 93) return MODE_START;
    if (p < 97) return MODE_QUERY;
    if (p < 99) return MODE_UNUSED;
    return MODE_CLEAR;
  endfunction

  function automatic logic [31:0] rand_value();
    int p;
    p = $urandom_range(15);
    if (p == 0) return 32'h0;
    if (p == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  task automatic send_item(input logic [MODE_W-1:0] m, input logic [31:0] v,
                           input bit typed, input cursor_view_t want);
    cursor_view_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= v;
    in_tuser <= m;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = predict_list_cmd(m, v);
    awaited_views.push_back(typed ? want : r);
    sent++;
  endtask

  task automatic fill_pool();
    while (entries < POOL)
      send_item($urandom_range(1) ? MODE_ATTACH : MODE_INSERT, rand_value(), 1'b0, '0);
    // pool full: both kinds of add are refused
    send_item(MODE_INSERT, rand_value(), 1'b0, '0);
    send_item(MODE_ATTACH, rand_value(), 1'b0, '0);
    send_item(MODE_START, rand_value(), 1'b0, '0);
    repeat (12) send_item($urandom_range(3) == 0 ? MODE_REMOVE : MODE_ADV,
                          rand_value(), 1'b0, '0);
    send_item(MODE_INSERT, rand_value(), 1'b0, '0);
  endtask

  task automatic run_phase(input int n_cmds, input int idle_pct, input int stall,
                           input bit fill_now);
    int first;
    int pick;
    int len;
    send_idle_pct = idle_pct;
    stall_pct = stall;
    first = sent;
    if (fill_now) fill_pool();
    while (sent - first < n_cmds) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        len = $urandom_range(20, 4);
        repeat (len) send_item(edit_mode(), rand_value(), 1'b0, '0);
      end else if (pick < 80) begin
        send_item(MODE_START, rand_value(), 1'b0, '0);
        len = $urandom_range(16, 1);
        repeat (len) send_item($urandom_range(5) == 0 ? MODE_REMOVE : MODE_ADV,
                               rand_value(), 1'b0, '0);
      end else if (pick < 94) begin
        len = $urandom_range(6, 1);
        repeat (len) send_item(MODE_W'($urandom_range(7)), $urandom, 1'b0, '0);
      end else begin
        send_item(MODE_CLEAR, rand_value(), 1'b0, '0);
      end
    end
  endtask

  task automatic check_field(input string name, input longint unsigned got,
                             input longint unsigned want);
    if (got != want) begin
      $display("mismatch on %s: got 0x%0h, expected 0x%0h", name, got, want);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_asks != hold_served) begin
      out_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_served <= hold_asks;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_view = '{out_tdata[31:0], out_tuser[0], out_tdata[40:32], out_tuser[1]};
      if (awaited_views.size() == 0) begin
        $display("result item with nothing expected: 0x%0h", got_view);
        mismatches++;
      end else begin
        want_view = awaited_views.pop_front();
        check_field("current_value", got_view.cur, want_view.cur);
        check_field("has_item", got_view.has, want_view.has);
        check_field("item_count", got_view.cnt, want_view.cnt);
        check_field("error", got_view.err, want_view.err);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    empty_list();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++)
      send_item(plan[i].mode, plan[i].value, plan[i].typed, plan[i].want);

    run_phase(500, 0, 0, 1'b1);
    run_phase(350, 85, 0, 1'b0);
    run_phase(350, 0, 85, 1'b0);

    // receiver holds off while commands keep coming
    send_idle_pct = 0;
    stall_pct = 0;
    hold_asks++;
    repeat (40) send_item(edit_mode(), rand_value(), 1'b0, '0);

    run_phase(500, 21, 21, 1'b1);

    in_tvalid <= 1'b0;
    while (awaited_views.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
